// File: hdl/sqrot_pkg.sv
// Shared types, constants and helpers of the square tile rotator.
package sqrot_pkg;

  // Largest tile side supported by the store
  localparam int unsigned TILE_DIM    = 8;
  localparam int unsigned STORE_DEPTH = TILE_DIM * TILE_DIM;
  localparam int unsigned DIM_W       = (TILE_DIM > 1) ? $clog2(TILE_DIM) : 1;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SIZE_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = SIZE_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TILE_DIM);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE = 2'd0,
    CFG_ROT_CCW   = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic load_step;
    logic read_step;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_last;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  // Store address of a tile position
  function automatic logic [ADDR_W-1:0] tile_addr(input logic [DIM_W-1:0] row,
                                                  input logic [DIM_W-1:0] col);
    tile_addr = ADDR_W'(row * TILE_DIM + col);
  endfunction

endpackage

// File: hdl/sqrot_ram.sv
// Generic simple dual-port RAM with registered read data.
module sqrot_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sqrot_ctrl.sv
// Load/emit sequencer of the square tile rotator.
module sqrot_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  sqrot_pkg::dp_status_t status_i,
  output sqrot_pkg::ctrl_cmd_t  cmd_o
);
  import sqrot_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && status_i.load_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.emit_last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.load_step = in_valid_i;
      end
      ST_EMIT: begin
        cmd_o.read_step = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/sqrot_dp.sv
// Datapath: config registers, tile counters, tile store and output stage.
module sqrot_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sqrot_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sqrot_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  sqrot_pkg::ctrl_cmd_t             cmd_i,
  output sqrot_pkg::dp_status_t            status_o,
  input  logic [sqrot_pkg::WORD_W-1:0]     element_value_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [sqrot_pkg::WORD_W-1:0]     rotated_value_o,
  output logic                             last_of_tile_o
);
  import sqrot_pkg::*;

  logic [SIZE_W-1:0] tile_size_q, tile_size_d;
  logic              ccw_q, ccw_d;
  logic [DIM_W-1:0]  side_m1;
  logic [DIM_W-1:0]  ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [DIM_W-1:0]  em_row_q, em_row_d, em_col_q, em_col_d;
  logic              out_valid_q, out_valid_d;
  logic              last_q, last_d;
  logic              ld_row_end, ld_col_end, em_row_end, em_col_end;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DIM_W-1:0]  src_row, src_col;

  // Clamp the programmed size into one..TILE_DIM, kept as side minus one
  always_comb begin
    if (tile_size_q == '0) begin
      side_m1 = '0;
    end else if (tile_size_q > SIZE_W'(TILE_DIM)) begin
      side_m1 = DIM_W'(TILE_DIM - 1);
    end else begin
      side_m1 = DIM_W'(tile_size_q - SIZE_W'(1));
    end
  end

  assign ld_col_end = (ld_col_q == side_m1);
  assign ld_row_end = (ld_row_q == side_m1);
  assign em_col_end = (em_col_q == side_m1);
  assign em_row_end = (em_row_q == side_m1);

  assign status_o.load_last = ld_row_end && ld_col_end;
  assign status_o.emit_last = em_row_end && em_col_end;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Configuration writes; a size write also restarts the load position
  always_comb begin
    tile_size_d = tile_size_q;
    ccw_d       = ccw_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TILE_SIZE: tile_size_d = cfg_wdata_i[SIZE_W-1:0];
        CFG_ROT_CCW:   ccw_d       = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Advance load position, wrap at tile end
  always_comb begin
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    if (cfg_we_i && (cfg_index_i == CFG_TILE_SIZE)) begin
      ld_row_d = '0;
      ld_col_d = '0;
    end else if (cmd_i.load_step) begin
      if (ld_col_end) begin
        ld_col_d = '0;
        ld_row_d = ld_row_end ? '0 : ld_row_q + DIM_W'(1);
      end else begin
        ld_col_d = ld_col_q + DIM_W'(1);
      end
    end
  end

  // Advance emit position and the output stage
  always_comb begin
    em_row_d    = em_row_q;
    em_col_d    = em_col_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    if (cmd_i.read_step) begin
      out_valid_d = 1'b1;
      last_d      = em_row_end && em_col_end;
      if (em_col_end) begin
        em_col_d = '0;
        em_row_d = em_row_end ? '0 : em_row_q + DIM_W'(1);
      end else begin
        em_col_d = em_col_q + DIM_W'(1);
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Source position of the rotated element
  always_comb begin
    if (ccw_q) begin
      src_row = em_col_q;
      src_col = side_m1 - em_row_q;
    end else begin
      src_row = side_m1 - em_col_q;
      src_col = em_row_q;
    end
  end

  assign waddr = tile_addr(ld_row_q, ld_col_q);
  assign raddr = tile_addr(src_row, src_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= SIZE_RESET;
      ccw_q       <= 1'b0;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      em_row_q    <= '0;
      em_col_q    <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      tile_size_q <= tile_size_d;
      ccw_q       <= ccw_d;
      ld_row_q    <= ld_row_d;
      ld_col_q    <= ld_col_d;
      em_row_q    <= em_row_d;
      em_col_q    <= em_col_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // Tile store; its read register doubles as the output word register
  sqrot_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_step),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (cmd_i.read_step),
    .raddr_i (raddr),
    .rdata_o (rotated_value_o)
  );

  assign out_valid_o    = out_valid_q;
  assign last_of_tile_o = last_q;

endmodule

// File: hdl/square_tile_rotate_90_core.sv
// Top level of the square tile rotator: controller plus datapath.
// Loads n*n words, one per cycle while in_valid_i is high; after the last load the
// controller enters emit and the first rotated word leaves the store's read register.
// Emits n*n words at one per cycle while taken; the single tile store serves load and emit.
// The next tile's loading starts while the final rotated word still waits.
// Reset (async, active low) sets size 8, clockwise, empty output; the store is not cleared.
module square_tile_rotate_90_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sqrot_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sqrot_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [31:0]               element_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [31:0]               rotated_value_o,
  output logic                             last_of_tile_o
);
  import sqrot_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [WORD_W-1:0]  rot_word;

  sqrot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sqrot_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .element_value_i (element_value_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .rotated_value_o (rot_word),
    .last_of_tile_o  (last_of_tile_o)
  );

  assign in_ready_o      = cmd.in_ready;
  assign rotated_value_o = rot_word;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the square tile rotator: directed and random tiles against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqrot_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 200_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
  } rotated_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_TILE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic signed [31:0]    element_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [31:0]    rotated_value_o;
  logic                  last_of_tile_o;

  // Predictor state: its own copy of the store, the count and the registers
  logic [WORD_W-1:0] model_store [STORE_DEPTH];
  logic [SIZE_W-1:0] model_size  = SIZE_RESET;
  logic              model_ccw   = 1'b0;
  int unsigned       model_count = 0;
  rotated_word_t     expected_words [$];

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 52;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned elements_sent = 0;
  int unsigned words_checked = 0;
  int unsigned tiles_done    = 0;
  logic [TILE_DIM:1] sides_seen = '0;

  square_tile_rotate_90_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .rotated_value_o (rotated_value_o),
    .last_of_tile_o  (last_of_tile_o)
  );

  always #6 clk_i = ~clk_i;

  // Side length that a size register value selects
  function automatic int unsigned active_side(input logic [SIZE_W-1:0] size);
    if (size == 0) return 1;
    if (size > TILE_DIM) return TILE_DIM;
    return 32'(size);
  endfunction

  // Store one word; on the last word of the tile queue the rotated tile
  task automatic store_and_rotate(input logic [WORD_W-1:0] word);
    int unsigned n;
    int unsigned total;
    logic [ADDR_W-1:0] addr;
    rotated_word_t w;
    n = active_side(model_size);
    total = n * n;
    if (model_count >= total) model_count = 0;
    model_store[ADDR_W'((model_count / n) * TILE_DIM + (model_count % n))] = word;
    model_count++;
    if (model_count == total) begin
      model_count = 0;
      sides_seen[SIZE_W'(n)] = 1'b1;
      tiles_done++;
      for (int unsigned r = 0; r < n; r++) begin
        for (int unsigned c = 0; c < n; c++) begin
          addr = model_ccw ? ADDR_W'(c * TILE_DIM + (n - 1 - r))
                           : ADDR_W'((n - 1 - c) * TILE_DIM + r);
          w.value = model_store[addr];
          w.last = (r * n + c == total - 1);
          expected_words.push_back(w);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    error_count++;
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Check each taken word, then track register writes and accepted words
  always @(posedge clk_i) begin : monitor
    rotated_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected rotated word", '0, rotated_value_o);
        end else begin
          want = expected_words.pop_front();
          if (rotated_value_o !== want.value)
            report_mismatch("rotated_value", want.value, rotated_value_o);
          if (last_of_tile_o !== want.last)
            report_mismatch("last_of_tile", WORD_W'(want.last), WORD_W'(last_of_tile_o));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TILE_SIZE: begin
            model_size = cfg_wdata_i;
            model_count = 0;
          end
          CFG_ROT_CCW: model_ccw = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) store_and_rotate(element_value_i);
    end
  end

  // Stall the output side at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout with %0d rotated words outstanding", expected_words.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one word after a random idle gap and hold it until taken
  task automatic send_element(input logic [WORD_W-1:0] word);
    int unsigned gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_value_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    elements_sent++;
  endtask

  // Hold the input until every queued word has come out, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4: return WORD_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Mostly small tiles, a few full-size, oversized and zero settings
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return SIZE_W'($urandom_range(1, 3));
    if (r < 80) return SIZE_W'($urandom_range(4, 6));
    if (r < 88) return SIZE_W'($urandom_range(7, 8));
    if (r < 94) return SIZE_W'($urandom_range(9, 15));
    return '0;
  endfunction

  task automatic send_run(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_element(pick_element());
  endtask

  // One-word tiles at the word extremes; size zero must act as one
  task automatic test_single_element_tiles();
    drain_results();
    write_reg(CFG_TILE_SIZE, 4'd1);
    write_reg(CFG_ROT_CCW, 4'd0);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    drain_results();
    write_reg(CFG_TILE_SIZE, 4'd0);
    write_reg(CFG_ROT_CCW, 4'd1);
    send_element(32'h0000_0000);
    send_element(32'hffff_ffff);
  endtask

  // 2x2 tile with distinct words, both directions
  task automatic test_two_by_two_directions();
    drain_results();
    write_reg(CFG_TILE_SIZE, 4'd2);
    write_reg(CFG_ROT_CCW, 4'd0);
    send_element(32'h0000_0011);
    send_element(32'h0000_0012);
    send_element(32'h0000_0021);
    send_element(32'h0000_0022);
    drain_results();
    write_reg(CFG_ROT_CCW, 4'd1);
    send_element(32'h8000_0011);
    send_element(32'h7fff_0012);
    send_element(32'hffff_0021);
    send_element(32'h0001_0022);
  endtask

  // Drop a partial 3x3 tile by rewriting the size, then load a fresh 2x2
  task automatic test_size_rewrite_mid_tile();
    drain_results();
    write_reg(CFG_TILE_SIZE, 4'd3);
    write_reg(CFG_ROT_CCW, 4'd0);
    for (int unsigned i = 0; i < 5; i++) send_element(32'ha000_0000 | i);
    drain_results();
    write_reg(CFG_TILE_SIZE, 4'd2);
    for (int unsigned i = 0; i < 4; i++) send_element(32'h5000_0000 | i);
  endtask

  // Flip the direction halfway through a tile; writes past the list must not disturb it
  task automatic test_direction_rewrite_mid_tile();
    drain_results();
    write_reg(CFG_TILE_SIZE, 4'd2);
    write_reg(CFG_ROT_CCW, 4'd0);
    send_element(32'h0c00_0001);
    send_element(32'h0c00_0002);
    drain_results();
    write_reg(CFG_UNMAPPED_LO, 4'hf);
    write_reg(CFG_UNMAPPED_HI, 4'h1);
    write_reg(CFG_ROT_CCW, 4'd1);
    send_element(32'h0c00_0003);
    send_element(32'h0c00_0004);
  endtask

  // Random tiles under one idle setting; some tiles are cut short or change direction
  task automatic test_random_tiles(input int unsigned send_pct, input int unsigned recv_pct,
                                   input logic [SIZE_W-1:0] first_size,
                                   input int unsigned budget);
    int unsigned start;
    int unsigned n;
    int unsigned tiles;
    int unsigned split;
    logic [SIZE_W-1:0] size;
    bit first_pass;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = elements_sent;
    first_pass = 1'b1;
    while (elements_sent - start < budget) begin
      size = first_pass ? first_size : pick_size();
      n = active_side(size);
      drain_results();
      write_reg(CFG_TILE_SIZE, size);
      write_reg(CFG_ROT_CCW, CFG_DATA_W'($urandom_range(0, 1)));
      tiles = (n >= 6) ? 1 : $urandom_range(1, 4);
      for (int unsigned t = 0; t < tiles; t++) begin
        if (!first_pass && $urandom_range(0, 7) == 0) begin
          send_run($urandom_range(0, n * n - 1));
          break;
        end
        if (n > 1 && $urandom_range(0, 4) == 0) begin
          split = $urandom_range(1, n * n - 1);
          send_run(split);
          drain_results();
          write_reg(CFG_ROT_CCW, CFG_DATA_W'($urandom_range(0, 1)));
          send_run(n * n - split);
        end else begin
          send_run(n * n);
        end
      end
      first_pass = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_element_tiles();
    test_two_by_two_directions();
    test_size_rewrite_mid_tile();
    test_direction_rewrite_mid_tile();
    test_random_tiles(37, 52, 4'd15, 70);
    test_random_tiles(52, 37, 4'd7, 60);
    test_random_tiles(0, 0, 4'd8, 70);
    drain_results();

    $display("sent %0d words, rotated %0d tiles, checked %0d output words",
             elements_sent, tiles_done, words_checked);
    $display("tile sides completed (8 down to 1): %b, %0d mismatches",
             sides_seen, error_count);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/sqrot_pkg.sv
hdl/sqrot_ram.sv
hdl/sqrot_ctrl.sv
hdl/sqrot_dp.sv
hdl/square_tile_rotate_90_core.sv
tb/tb.sv
